FILE: rtl/modexp_pkg.sv
// Shared constants, types and command/status structs of the modular exponentiation block.
`default_nettype none

package modexp_pkg;

    localparam int unsigned EXP_WIDTH = 32;
    localparam int unsigned VAL_W     = 30;
    localparam int unsigned CNT_W     = $clog2(EXP_WIDTH + 1);

    localparam logic [VAL_W-1:0] PRIME = 30'd1000000007;
    localparam logic [VAL_W-1:0] ONE   = 30'd1;

    // Barrett constant floor(2^60 / P), 31 bits wide
    localparam logic [63:0] BARRETT_MU_FULL = 64'h1000_0000_0000_0000 / 64'd1000000007;
    localparam logic [30:0] BARRETT_MU      = BARRETT_MU_FULL[30:0];

    // Fermat exponent for the inverse
    localparam logic [EXP_WIDTH-1:0] INV_EXP = EXP_WIDTH'(64'd1000000005);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MUL    = 5'b00010,
        ST_SQR    = 5'b00100,
        ST_WAIT   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    typedef struct packed {
        logic load;
        logic issue_mul;
        logic issue_sqr;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic sq_wr;
        logic bit_set;
        logic last_bit;
    } stat_t;

endpackage

`default_nettype wire

FILE: rtl/modexp_ctrl.sv
// Sequencer: per exponent bit, a multiply where the bit is set and one square; output handoff.
`default_nettype none

module modexp_ctrl import modexp_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                // multiply only where the exponent bit is set
                cmd.issue_mul = stat.bit_set;
                state_next    = ST_SQR;
            end
            ST_SQR: begin
                cmd.issue_sqr = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT: begin
                if (stat.sq_wr) begin
                    state_next = stat.last_bit ? ST_FINISH : ST_MUL;
                end
            end
            ST_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/modexp_mulmod.sv
// Four-stage pipelined modular multiplier with Barrett reduction.
`default_nettype none

module modexp_mulmod import modexp_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             op_valid,
    input  wire logic             op_to_sq,
    input  wire logic [VAL_W-1:0] op_a,
    input  wire logic [VAL_W-1:0] op_b,
    output logic                  res_valid,
    output logic                  res_to_sq,
    output logic [VAL_W-1:0]      res
);

    logic [3:0]       valid_reg, valid_next;
    logic [3:0]       to_sq_reg, to_sq_next;

    logic [59:0]      prod_reg;
    logic [61:0]      qm_reg;
    logic [31:0]      xlo2_reg, xlo3_reg;
    logic [31:0]      qp_reg;
    logic [VAL_W-1:0] res_reg;

    logic [60:0]      qp_full;
    logic [30:0]      q3;
    logic [31:0]      r0, r1, r2;
    logic [31:0]      p32, p2x32;

    assign valid_next = {valid_reg[2:0], op_valid};
    assign to_sq_next = {to_sq_reg[2:0], op_to_sq};

    assign q3      = qm_reg[61:31];
    assign qp_full = 61'(q3) * 61'(PRIME);

    // remainder is below 3P, so it fits in 32 bits
    assign p32   = 32'(PRIME);
    assign p2x32 = {p32[30:0], 1'b0};
    assign r0    = xlo3_reg - qp_reg;
    assign r1    = r0 - p32;
    assign r2    = r0 - p2x32;

    always_ff @(posedge aclk) begin
        prod_reg <= 60'(op_a) * 60'(op_b);
        qm_reg   <= 62'(prod_reg[59:29]) * 62'(BARRETT_MU);
        xlo2_reg <= prod_reg[31:0];
        qp_reg   <= qp_full[31:0];
        xlo3_reg <= xlo2_reg;
        if (r0 >= p2x32) begin
            res_reg <= r2[VAL_W-1:0];
        end else if (r0 >= p32) begin
            res_reg <= r1[VAL_W-1:0];
        end else begin
            res_reg <= r0[VAL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            to_sq_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            to_sq_reg <= to_sq_next;
        end
    end

    assign res_valid = valid_reg[3];
    assign res_to_sq = to_sq_reg[3];
    assign res       = res_reg;

endmodule

`default_nettype wire

FILE: rtl/modexp_datapath.sv
// Accumulator, square, exponent shifter, bit counter and output register.
`default_nettype none

module modexp_datapath import modexp_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cmd_t                 cmd,
    input  wire logic                 in_kind,
    input  wire logic [VAL_W-1:0]     in_base,
    input  wire logic [EXP_WIDTH-1:0] in_exponent,
    output stat_t                     stat,
    output logic [VAL_W-1:0]          out_power
);

    logic [VAL_W-1:0]     acc_reg, sq_reg, out_reg;
    logic [EXP_WIDTH-1:0] exp_reg;
    logic [CNT_W-1:0]     cnt_reg;

    logic [VAL_W-1:0]     base_red;
    logic                 mm_valid, mm_to_sq;
    logic [VAL_W-1:0]     mm_a;
    logic                 res_valid, res_to_sq;
    logic [VAL_W-1:0]     res;

    // base is below 2P, one subtract reduces it
    assign base_red = (in_base >= PRIME) ? in_base - PRIME : in_base;

    assign mm_valid = cmd.issue_mul | cmd.issue_sqr;
    assign mm_to_sq = cmd.issue_sqr;
    assign mm_a     = cmd.issue_sqr ? sq_reg : acc_reg;

    modexp_mulmod u_mulmod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op_valid  (mm_valid),
        .op_to_sq  (mm_to_sq),
        .op_a      (mm_a),
        .op_b      (sq_reg),
        .res_valid (res_valid),
        .res_to_sq (res_to_sq),
        .res       (res)
    );

    assign stat.sq_wr    = res_valid & res_to_sq;
    assign stat.bit_set  = exp_reg[0];
    assign stat.last_bit = (cnt_reg == CNT_W'(EXP_WIDTH - 1));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            acc_reg <= ONE;
            sq_reg  <= base_red;
            exp_reg <= in_kind ? INV_EXP : in_exponent;
            cnt_reg <= '0;
        end else if (res_valid) begin
            if (res_to_sq) begin
                sq_reg  <= res;
                exp_reg <= exp_reg >> 1;
                cnt_reg <= cnt_reg + CNT_W'(1);
            end else begin
                acc_reg <= res;
            end
        end
        if (cmd.load_out) begin
            out_reg <= acc_reg;
        end
    end

    assign out_power = out_reg;

endmodule

`default_nettype wire

FILE: rtl/modular_exponentiation_top.sv
// Top level of the modular exponentiation block (stream in, stream out).
//
// Computes base^exponent mod 1000000007 by right-to-left square-and-multiply, or, with
// s_tuser[0] set, the modular inverse base^(P-2) mod P (a base of zero yields zero). Bases
// of P or more are reduced first. One item is worked on at a time: the square of each of the 32
// exponent bits must clear the 4-stage Barrett multiplier pipeline before the next bit can
// issue. The finished result sits in an output register, so a new item is taken while the
// previous result waits on m_tready.
`default_nettype none

module modular_exponentiation_top import modexp_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [29:0] base, [61:30] exponent, [63:62] zero
    input  wire logic [0:0]  s_tuser,   // [0] kind: 0 power, 1 inverse
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [29:0] power, [31:30] zero
);

    cmd_t             cmd;
    stat_t            stat;
    logic [VAL_W-1:0] power;

    modexp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    modexp_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_kind     (s_tuser[0]),
        .in_base     (s_tdata[29:0]),
        .in_exponent (s_tdata[61:30]),
        .stat        (stat),
        .out_power   (power)
    );

    assign m_tdata = {2'b00, power};

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Stream testbench for modular_exponentiation_top: power and Fermat inverse mod 1000000007.
`default_nettype none

module tb_top;
    import modexp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned MODULUS     = 64'd1000000007;
    localparam logic [29:0]     BASE_MAX    = 30'h3FFF_FFFF;
    localparam logic [29:0]     BASE_TOP    = 30'd1000000006;
    localparam logic [29:0]     BASE_P      = 30'd1000000007;
    localparam logic [31:0]     EXP_ALL     = 32'hFFFF_FFFF;
    localparam logic [31:0]     INVERSE_EXP = 32'd1000000005;
    localparam logic            KIND_POWER   = 1'b0;
    localparam logic            KIND_INVERSE = 1'b1;
    localparam int              RANDOM_JOBS  = 1200;
    localparam int              QUIET_FROM   = 400;   // no random idling on either side in this window
    localparam int              QUIET_TO     = 700;
    localparam int              SETTLE_CYCLES = 400;
    localparam int              STALL_LIMIT   = 4000;

    typedef struct packed {
        logic        kind;
        logic [29:0] base;
        logic [31:0] exponent;
        logic        drain;   // hold this job until every pending result is back
    } job_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    job_t        job_queue[$];
    logic [29:0] power_queue[$];
    logic        in_taken = 1'b0;

    int sent_count    = 0;
    int taken_count   = 0;
    int inverse_count = 0;
    int result_count  = 0;
    int err_count     = 0;
    int stall_cycles  = 0;

    modular_exponentiation_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    // Right-to-left square-and-multiply over all 32 exponent bits.
    function automatic logic [29:0] mod_power(logic [29:0] base, logic [31:0] exponent);
        longint unsigned acc;
        longint unsigned sq;
        acc = 1;
        sq  = base;
        sq  = sq % MODULUS;
        for (int i = 0; i < 32; i++) begin
            if (exponent[i])
                acc = (acc * sq) % MODULUS;
            sq = (sq * sq) % MODULUS;
        end
        return acc[29:0];
    endfunction

    task automatic add_job(logic kind, logic [29:0] base, logic [31:0] exponent,
                           logic drain = 1'b0);
        job_t job;
        job.kind     = kind;
        job.base     = base;
        job.exponent = exponent;
        job.drain    = drain;
        job_queue.insert(job_queue.size(), job);
    endtask

    function automatic logic [29:0] pick_base();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: return 30'd0;
                    1: return 30'd1;
                    2: return BASE_TOP;
                    3: return BASE_P;
                    default: return BASE_MAX;
                endcase
            end
            1: return 30'($urandom_range(32'(BASE_MAX), 32'(BASE_P)));
            default: return 30'($urandom_range(32'(BASE_TOP), 0));
        endcase
    endfunction

    function automatic logic [31:0] pick_exponent();
        case ($urandom_range(7))
            0: return 32'($urandom_range(3));
            1: return 32'd1 << $urandom_range(31);
            2: return EXP_ALL;
            default: return $urandom;
        endcase
    endfunction

    // Sender and receiver, driven on the falling edge.
    always @(negedge aclk) begin : drive_stimulus
        logic next_valid;
        logic idle;
        job_t job;
        if (aresetn) begin
            next_valid = s_tvalid;
            if (s_tvalid && in_taken)
                next_valid = 1'b0;
            if (!next_valid && job_queue.size() > 0) begin
                idle = (sent_count < QUIET_FROM || sent_count >= QUIET_TO)
                       && ($urandom_range(99) < 11);
                if (job_queue[0].drain && power_queue.size() != 0)
                    idle = 1'b1;
                if (!idle) begin
                    job = job_queue.pop_front();
                    s_tdata <= {2'b00, job.exponent, job.base};
                    s_tuser <= job.kind;
                    next_valid = 1'b1;
                    sent_count++;
                end
            end
            s_tvalid <= next_valid;
            m_tready <= !((result_count < QUIET_FROM || result_count >= QUIET_TO)
                          && ($urandom_range(99) < 11));
        end
    end

    // Predict on each input transfer, check on each output transfer.
    always @(posedge aclk) begin : check_results
        logic [31:0] exp_used;
        logic [29:0] want;
        logic        s_fire;
        logic        m_fire;
        s_fire = aresetn && s_tvalid && s_tready;
        m_fire = aresetn && m_tvalid && m_tready;
        in_taken <= s_fire;
        if (s_fire) begin
            exp_used = (s_tuser[0] == KIND_INVERSE) ? INVERSE_EXP : s_tdata[61:30];
            power_queue.insert(power_queue.size(), mod_power(s_tdata[29:0], exp_used));
            taken_count++;
            if (s_tuser[0] == KIND_INVERSE)
                inverse_count++;
        end
        if (m_fire) begin
            result_count++;
            if (power_queue.size() == 0) begin
                $error("unexpected result: power actual %0d", m_tdata[29:0]);
                err_count++;
            end else begin
                want = power_queue.pop_front();
                if (m_tdata[29:0] !== want) begin
                    $error("power mismatch: expected %0d, actual %0d", want, m_tdata[29:0]);
                    err_count++;
                end
            end
        end
        if (s_fire || m_fire || !aresetn)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("modular_exponentiation_top verification failed");
            $finish;
        end
    end

    initial begin
        logic kind;

        // zero exponent
        add_job(KIND_POWER, 30'd0, 32'd0);
        add_job(KIND_POWER, 30'd5, 32'd0);
        add_job(KIND_POWER, BASE_MAX, 32'd0);
        // field extremes
        add_job(KIND_POWER, 30'd0, 32'd1);
        add_job(KIND_POWER, 30'd1, EXP_ALL);
        add_job(KIND_POWER, BASE_TOP, EXP_ALL);
        add_job(KIND_POWER, BASE_TOP, 32'd2);
        add_job(KIND_POWER, 30'd2, 32'd31);
        add_job(KIND_POWER, 30'd3, 32'h8000_0000);
        add_job(KIND_POWER, 30'h2AAA_AAAA, 32'h5555_5555);
        add_job(KIND_POWER, 30'h1555_5555, 32'hAAAA_AAAA);
        // base at or above the prime
        add_job(KIND_POWER, BASE_P, 32'd5);
        add_job(KIND_POWER, BASE_P + 30'd1, EXP_ALL);
        add_job(KIND_POWER, BASE_MAX, 32'd12345);
        // inverse, including zero and unreduced bases; exponent field is don't-care
        add_job(KIND_INVERSE, 30'd0, 32'd0);
        add_job(KIND_INVERSE, 30'd1, EXP_ALL);
        add_job(KIND_INVERSE, 30'd2, 32'd7);
        add_job(KIND_INVERSE, BASE_TOP, 32'd0);
        add_job(KIND_INVERSE, BASE_P, EXP_ALL);
        add_job(KIND_INVERSE, BASE_MAX, 32'd1);
        add_job(KIND_INVERSE, 30'd123456789, 32'hDEAD_BEEF);

        for (int n = 0; n < RANDOM_JOBS; n++) begin
            kind = ($urandom_range(3) == 0) ? KIND_INVERSE : KIND_POWER;
            add_job(kind, pick_base(), pick_exponent(), n == 0 || n == RANDOM_JOBS / 2);
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (job_queue.size() != 0 || s_tvalid || power_queue.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (power_queue.size() != 0) begin
            $error("%0d expected results never arrived", power_queue.size());
            err_count++;
        end
        $display("%0d items sent (%0d power, %0d inverse), %0d results checked, %0d errors",
                 taken_count, taken_count - inverse_count, inverse_count, result_count,
                 err_count);
        if (err_count == 0)
            $display("modular_exponentiation_top verification clean");
        else
            $display("modular_exponentiation_top verification failed");
        $finish;
    end

endmodule

`default_nettype wire
